// ----- rtl/sem_pkg.sv -----
// ----------------------------------------------------------------------------
// sem_pkg
// shared types, constants and the sobel magnitude function
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int MAX_ROW_LENGTH = 128;
  localparam int COL_W          = $clog2(MAX_ROW_LENGTH);
  localparam int ROW_WIDTH_W    = 8;
  localparam int ROW_COUNT_W    = 16;
  localparam int WX_W           = (COL_W + 1 > ROW_WIDTH_W) ? COL_W + 1 : ROW_WIDTH_W;
  localparam int PIX_W          = 8;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 3;

  localparam int JOBQ_DEPTH     = 4;
  localparam int JOBQ_PTR_W     = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CNT_W     = $clog2(JOBQ_DEPTH + 1);
  localparam int OUTQ_DEPTH     = 4;
  localparam int OUTQ_PTR_W     = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W     = $clog2(OUTQ_DEPTH + 1);

  typedef logic [PIX_W-1:0] pixel_t;
  // index row*3+col, rows top/middle/bottom, cols left/centre/right
  typedef logic [8:0][PIX_W-1:0] win_t;

  typedef enum logic [0:0] {
    REG_ROW_WIDTH = 1'b0,
    REG_ROW_COUNT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [ROW_WIDTH_W-1:0] row_width;
    logic [ROW_COUNT_W-1:0] row_count;
  } cfg_t;

  typedef struct packed {
    win_t win;
    logic emit_main;
    logic emit_end;
    logic frame_end;
  } job_t;

  typedef struct packed {
    pixel_t edge_value;
    logic   end_of_row;
    logic   end_of_frame;
    logic   last_of_run;
  } result_t;

  function automatic pixel_t edge_of(win_t w);
    logic signed [11:0] a [9];
    logic signed [11:0] sx;
    logic signed [11:0] sy;
    logic [11:0]        ax;
    logic [11:0]        ay;
    logic [12:0]        s;
    for (int i = 0; i < 9; i++) begin
      a[i] = signed'({4'b0000, w[i]});
    end
    sx = a[0] - a[6] + ((a[1] - a[7]) <<< 1) + a[2] - a[8];
    sy = a[2] - a[0] + ((a[5] - a[3]) <<< 1) + a[8] - a[6];
    ax = sx[11] ? 12'(-sx) : 12'(sx);
    ay = sy[11] ? 12'(-sy) : 12'(sy);
    s  = {1'b0, ax} + {1'b0, ay};
    return s[10:3];
  endfunction

endpackage

// ----- rtl/sem_regs.sv -----
// ----------------------------------------------------------------------------
// sem_regs
// apb configuration registers: row width and row count
// ----------------------------------------------------------------------------
module sem_regs import sem_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_idx_t idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_width <= ROW_WIDTH_W'(128);
      cfg.row_count <= ROW_COUNT_W'(128);
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        REG_ROW_WIDTH: cfg.row_width <= pwdata[ROW_WIDTH_W-1:0];
        REG_ROW_COUNT: cfg.row_count <= pwdata[ROW_COUNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ROW_WIDTH: prdata = APB_DATA_W'(cfg.row_width);
      REG_ROW_COUNT: prdata = APB_DATA_W'(cfg.row_count);
    endcase
  end

endmodule

// ----- rtl/sem_front.sv -----
// ----------------------------------------------------------------------------
// sem_front
// pixel intake: line buffers, 3x3 window, row and frame tracking
// ----------------------------------------------------------------------------
module sem_front import sem_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   push,
  input  pixel_t pixel,
  input  logic   is_flush,
  output logic   full,
  input  logic   job_full,
  output logic   job_push,
  output job_t   job
);

  pixel_t upper_line  [MAX_ROW_LENGTH];
  pixel_t middle_line [MAX_ROW_LENGTH];

  pixel_t                 top_rd;
  pixel_t                 mid_rd;
  logic [COL_W-1:0]       column_index;
  logic [COL_W-1:0]       column_index_next;
  logic [COL_W-1:0]       rd_addr;
  logic [ROW_COUNT_W-1:0] row_index;
  logic                   first_row_flag;
  win_t                   win;
  win_t                   win_next;

  logic             accept;
  pixel_t           top;
  pixel_t           mid;
  pixel_t           bot;
  pixel_t [2:0]     col;
  logic [WX_W-1:0]  w_raw;
  logic [WX_W-1:0]  w_eff;
  logic             at_end;
  logic             frame_end;

  assign full   = job_full;
  assign accept = push && !job_full;

  always_comb begin
    bot = is_flush ? mid_rd : pixel;
    top = first_row_flag ? bot : top_rd;
    mid = first_row_flag ? bot : mid_rd;
    col = {bot, mid, top};

    w_raw = WX_W'(cfg.row_width);
    if (w_raw < WX_W'(2)) begin
      w_eff = WX_W'(2);
    end else if (w_raw > WX_W'(MAX_ROW_LENGTH)) begin
      w_eff = WX_W'(MAX_ROW_LENGTH);
    end else begin
      w_eff = w_raw;
    end
    at_end    = (WX_W'(column_index) + WX_W'(1)) >= w_eff;
    frame_end = row_index >= cfg.row_count;

    for (int r = 0; r < 3; r++) begin
      if (column_index == '0) begin
        win_next[r*3+0] = col[r];
        win_next[r*3+1] = col[r];
      end else begin
        win_next[r*3+0] = win[r*3+1];
        win_next[r*3+1] = win[r*3+2];
      end
      win_next[r*3+2] = col[r];
    end

    column_index_next = at_end ? '0 : column_index + COL_W'(1);
    rd_addr           = accept ? column_index_next : column_index;

    job.win       = win_next;
    job.emit_main = !first_row_flag && (column_index != '0);
    job.emit_end  = !first_row_flag && at_end;
    job.frame_end = frame_end;
    job_push      = accept && (job.emit_main || job.emit_end);
  end

  // line memories, read data registered for the next column
  always_ff @(posedge clk) begin
    if (accept) begin
      upper_line[column_index]  <= mid;
      middle_line[column_index] <= bot;
    end
    top_rd <= upper_line[rd_addr];
    mid_rd <= middle_line[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index   <= '0;
      row_index      <= '0;
      first_row_flag <= 1'b1;
      win            <= '0;
    end else if (accept) begin
      column_index <= column_index_next;
      win          <= win_next;
      if (at_end) begin
        if (frame_end) begin
          row_index      <= '0;
          first_row_flag <= 1'b1;
        end else begin
          row_index      <= row_index + ROW_COUNT_W'(1);
          first_row_flag <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- rtl/sem_job_queue.sv -----
// ----------------------------------------------------------------------------
// sem_job_queue
// short queue of windows between intake and computation
// ----------------------------------------------------------------------------
module sem_job_queue import sem_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t job_in,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t job_out
);

  job_t                  slots [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] wptr;
  logic [JOBQ_PTR_W-1:0] rptr;
  logic [JOBQ_CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full    = count == JOBQ_CNT_W'(JOBQ_DEPTH);
  assign valid   = count != '0;
  assign job_out = slots[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + JOBQ_PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= rptr + JOBQ_PTR_W'(1);
      end
      count <= count + JOBQ_CNT_W'(do_push) - JOBQ_CNT_W'(do_pop);
    end
  end

endmodule

// ----- rtl/sem_back.sv -----
// ----------------------------------------------------------------------------
// sem_back
// edge magnitude per window and result queue towards the consumer
// ----------------------------------------------------------------------------
module sem_back import sem_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    job_valid,
  input  job_t    job,
  output logic    job_pop,
  input  logic    pop,
  output logic    empty,
  output result_t res
);

  result_t               slots [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wptr;
  logic [OUTQ_PTR_W-1:0] rptr;
  logic [OUTQ_CNT_W-1:0] count;
  logic                  phase;

  logic    room;
  logic    do_main;
  logic    gen;
  logic    do_pop;
  win_t    sel;
  result_t res_new;

  assign room   = count != OUTQ_CNT_W'(OUTQ_DEPTH);
  assign empty  = count == '0;
  assign res    = slots[rptr];
  assign do_pop = pop && !empty;

  always_comb begin
    do_main = job.emit_main && !phase;
    gen     = job_valid && room;
    job_pop = gen && (!do_main || !job.emit_end);
    for (int r = 0; r < 3; r++) begin
      if (do_main) begin
        sel[r*3+0] = job.win[r*3+0];
        sel[r*3+1] = job.win[r*3+1];
      end else begin
        sel[r*3+0] = job.win[r*3+1];
        sel[r*3+1] = job.win[r*3+2];
      end
      sel[r*3+2] = job.win[r*3+2];
    end
    res_new.edge_value   = edge_of(sel);
    res_new.end_of_row   = !do_main;
    res_new.end_of_frame = !do_main && job.frame_end;
    res_new.last_of_run  = !do_main || !job.emit_end;
  end

  always_ff @(posedge clk) begin
    if (gen) begin
      slots[wptr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
      phase <= 1'b0;
    end else begin
      if (gen) begin
        wptr  <= wptr + OUTQ_PTR_W'(1);
        phase <= do_main && job.emit_end;
      end
      if (do_pop) begin
        rptr <= rptr + OUTQ_PTR_W'(1);
      end
      count <= count + OUTQ_CNT_W'(gen) - OUTQ_CNT_W'(do_pop);
    end
  end

endmodule

// ----- rtl/sobel_edge_magnitude_stream.sv -----
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_stream
// streaming 3x3 sobel edge magnitude with two line buffers
// ----------------------------------------------------------------------------
// path: a pixel transfer's job is registered in the job queue, and each of its
//   results in the result queue; a row end's second result follows its first
// throughput: one pixel per cycle while the job queue has room; the result
//   queue drains one result per cycle while pop is high; row ends make two
// reset: clears counters, window and queues; line memories are not cleared
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_stream import sem_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,
  input  logic                   push,
  output logic                   full,
  input  logic [PIX_W-1:0]       pixel,
  input  logic                   is_flush,
  input  logic                   pop,
  output logic                   empty,
  output logic [PIX_W-1:0]       edge_value,
  output logic                   end_of_row,
  output logic                   end_of_frame,
  output logic                   last_of_run
);

  cfg_t    cfg;
  logic    job_full;
  logic    job_push;
  job_t    job_in;
  logic    job_pop;
  logic    job_valid;
  job_t    job_out;
  result_t res;

  sem_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sem_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .pixel    (pixel),
    .is_flush (is_flush),
    .full     (full),
    .job_full (job_full),
    .job_push (job_push),
    .job      (job_in)
  );

  sem_job_queue u_job_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .job_in  (job_in),
    .full    (job_full),
    .pop     (job_pop),
    .valid   (job_valid),
    .job_out (job_out)
  );

  sem_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job_out),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  assign edge_value   = res.edge_value;
  assign end_of_row   = res.end_of_row;
  assign end_of_frame = res.end_of_frame;
  assign last_of_run  = res.last_of_run;

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    job_full |-> !job_push)
    else $error("job pushed into a full queue");

  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && end_of_frame) |-> end_of_row)
    else $error("frame end without row end");

  a_row_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && end_of_row) |-> last_of_run)
    else $error("row end result not last of its run");

  a_empty_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> empty)
    else $error("results present after reset");

endmodule

// ----- test/tb_sobel_edge_magnitude_stream.sv -----
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude_stream
// Self-checking bench for the streaming sobel edge magnitude block. A queue
// of pixel and flush items is fed through the push/full side with random
// gaps. A predictor of its own models the line memories, the 3x3 taps and
// the row and frame counters, and builds the expected results. Every result
// popped from the block is compared field by field with the oldest one
// expected. Row width and row count are set over APB between idle phases.
// The phases cover the register extremes, width shrinks mid-row, flush rows
// and frame ends.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude_stream;
  import sem_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    pixel_t px;
    logic   flush;
  } feed_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  push = 1'b0;
  logic                  full;
  logic [PIX_W-1:0]      pixel = '0;
  logic                  is_flush = 1'b0;
  logic                  pop = 1'b0;
  logic                  empty;
  logic [PIX_W-1:0]      edge_value;
  logic                  end_of_row;
  logic                  end_of_frame;
  logic                  last_of_run;

  sobel_edge_magnitude_stream DUT (.*);

  // stimulus and scoreboard
  feed_t   pixel_q[$];
  result_t edge_q[$];
  int      in_flight = 0;
  bit      in_taken = 1'b0;
  bit      steady = 1'b0;
  int      send_gap = 0;
  int      hold_gap = 0;
  int      fail_count = 0;
  int      fed_count = 0;
  int      edge_count = 0;
  int      frame_count = 0;
  logic    drive_next;
  feed_t   cur_item;

  // predictor state
  logic [ROW_WIDTH_W-1:0] cfg_width = 8'd128;
  logic [ROW_COUNT_W-1:0] cfg_count = 16'd128;
  pixel_t                 upper_ln [MAX_ROW_LENGTH];
  pixel_t                 middle_ln [MAX_ROW_LENGTH];
  win_t                   taps = '0;
  int unsigned            col_idx = 0;
  logic [ROW_COUNT_W-1:0] row_idx = '0;
  logic                   first_row = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic pixel_t sobel_mag(win_t t);
    int gx;
    int gy;
    gx = int'(t[0]) - int'(t[6]) + 2 * (int'(t[1]) - int'(t[7])) + int'(t[2]) - int'(t[8]);
    gy = int'(t[2]) - int'(t[0]) + 2 * (int'(t[5]) - int'(t[3])) + int'(t[8]) - int'(t[6]);
    if (gx < 0) gx = -gx;
    if (gy < 0) gy = -gy;
    return pixel_t'((gx + gy) / 8);
  endfunction

  task automatic predict_pixel(pixel_t px, logic flush);
    int unsigned w;
    int unsigned c;
    pixel_t      top;
    pixel_t      mid;
    pixel_t      bot;
    win_t        tail;
    logic        at_end;
    logic        fend;
    w = cfg_width;
    if (w < 2) w = 2;
    if (w > MAX_ROW_LENGTH) w = MAX_ROW_LENGTH;
    c = (col_idx >= MAX_ROW_LENGTH) ? 0 : col_idx;
    top = upper_ln[c];
    mid = middle_ln[c];
    bot = flush ? mid : px;
    if (first_row) begin
      top = bot;
      mid = bot;
    end
    upper_ln[c] = mid;
    middle_ln[c] = bot;
    for (int r = 0; r < 3; r++) begin
      taps[r*3]   = taps[r*3+1];
      taps[r*3+1] = taps[r*3+2];
    end
    taps[2] = top;
    taps[5] = mid;
    taps[8] = bot;
    // replicate the left edge at the start of a row
    if (c == 0) begin
      for (int r = 0; r < 3; r++) begin
        taps[r*3]   = taps[r*3+2];
        taps[r*3+1] = taps[r*3+2];
      end
    end
    at_end = (c + 1 >= w);
    fend = at_end && (row_idx >= cfg_count);
    if (!first_row) begin
      if (c >= 1) edge_q.push_back('{sobel_mag(taps), 1'b0, 1'b0, !at_end});
      if (at_end) begin
        for (int r = 0; r < 3; r++) begin
          tail[r*3]   = taps[r*3+1];
          tail[r*3+1] = taps[r*3+2];
          tail[r*3+2] = taps[r*3+2];
        end
        edge_q.push_back('{sobel_mag(tail), 1'b1, fend, 1'b1});
      end
    end
    if (at_end) begin
      col_idx = 0;
      if (fend) begin
        row_idx = '0;
        first_row = 1'b1;
      end else begin
        row_idx = row_idx + 1'b1;
        first_row = 1'b0;
      end
    end else begin
      col_idx = (c + 1) & 8'hFF;
    end
  endtask

  // monitor: register writes, input transfers and result checks
  always @(posedge clk) begin
    in_taken = push && !full;
    if (rst) begin
      cfg_width = 8'd128;
      cfg_count = 16'd128;
      taps = '0;
      col_idx = 0;
      row_idx = '0;
      first_row = 1'b1;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[2]))
          REG_ROW_WIDTH: cfg_width = pwdata[ROW_WIDTH_W-1:0];
          REG_ROW_COUNT: cfg_count = pwdata[ROW_COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_taken) begin
        predict_pixel(pixel, is_flush);
        in_flight--;
        fed_count++;
      end
      if (pop && !empty) begin
        edge_count++;
        if (end_of_frame) frame_count++;
        if (edge_q.size() == 0) begin
          $error("result transfer with nothing expected: edge_value %0d", edge_value);
          fail_count++;
        end else begin
          result_t exp_r;
          exp_r = edge_q.pop_front();
          if (edge_value !== exp_r.edge_value) begin
            $error("edge_value: expected %0d, got %0d", exp_r.edge_value, edge_value);
            fail_count++;
          end
          if (end_of_row !== exp_r.end_of_row) begin
            $error("end_of_row: expected %0b, got %0b", exp_r.end_of_row, end_of_row);
            fail_count++;
          end
          if (end_of_frame !== exp_r.end_of_frame) begin
            $error("end_of_frame: expected %0b, got %0b", exp_r.end_of_frame, end_of_frame);
            fail_count++;
          end
          if (last_of_run !== exp_r.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", exp_r.last_of_run, last_of_run);
            fail_count++;
          end
        end
      end
    end
  end

  // pixel driver
  always @(negedge clk) begin
    if (!rst) begin
      drive_next = push && !in_taken;
      if (!drive_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pixel_q.size() != 0) begin
          if (!steady && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 5);
          end else begin
            cur_item = pixel_q.pop_front();
            pixel <= cur_item.px;
            is_flush <= cur_item.flush;
            drive_next = 1'b1;
          end
        end
      end
      push <= drive_next;
    end
  end

  // result side stalls
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_gap > 0) begin
        hold_gap--;
        pop <= 1'b0;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        hold_gap = $urandom_range(0, 5);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [APB_DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic feed(pixel_t p, logic f);
    pixel_q.push_back('{p, f});
    in_flight++;
  endtask

  task automatic drain();
    while (in_flight != 0 || edge_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic feed_random(int count, int unsigned w);
    int unsigned eff;
    int          run;
    pixel_t      p;
    eff = (w < 2) ? 2 : ((w > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH : w);
    while (count > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        // a row of flush items, as at the end of a frame
        run = (eff < count) ? eff : count;
        repeat (run) feed('0, 1'b1);
        count -= run;
      end else begin
        case ($urandom_range(0, 7))
          0: p = '0;
          1: p = '1;
          default: p = pixel_t'($urandom);
        endcase
        feed(p, $urandom_range(0, 11) == 0);
        count--;
      end
    end
  endtask

  task automatic run_phase(logic [APB_DATA_W-1:0] w, logic [APB_DATA_W-1:0] n, int count);
    cfg_write(REG_ROW_WIDTH, w);
    cfg_write(REG_ROW_COUNT, n);
    feed_random(count, w);
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // first row at reset settings fills every line memory entry
    repeat (MAX_ROW_LENGTH) feed(pixel_t'($urandom), 1'b0);
    drain();

    // short rows with extreme levels, flush row at frame end
    cfg_write(REG_ROW_WIDTH, 32'd4);
    cfg_write(REG_ROW_COUNT, 32'd2);
    feed(8'd255, 1'b0); feed(8'd0, 1'b0); feed(8'd255, 1'b0); feed(8'd0, 1'b0);
    feed(8'd0, 1'b0); feed(8'd255, 1'b0); feed(8'd0, 1'b0); feed(8'd255, 1'b0);
    repeat (4) feed('0, 1'b1);
    feed(8'd255, 1'b0); feed(8'd255, 1'b0); feed(8'd0, 1'b0); feed(8'd0, 1'b0);
    drain();

    // width below range acts as two, row count one gives two-row frames
    cfg_write(REG_ROW_WIDTH, 32'd0);
    cfg_write(REG_ROW_COUNT, 32'd1);
    feed(8'd255, 1'b0); feed(8'd0, 1'b0);
    feed('0, 1'b1); feed('0, 1'b1);
    feed(8'd0, 1'b0); feed(8'd255, 1'b0);
    drain();

    run_phase(32'd3, 32'd3, 60);
    run_phase(32'd2, 32'd0, 20);
    run_phase(32'd128, 32'd2, 140);
    run_phase(32'd255, 32'd1, 60);
    run_phase(32'd1, 32'd65535, 40);
    run_phase(32'd7, 32'd5, 40);
    run_phase($urandom_range(2, 40), $urandom_range(1, 6), 80);
    steady = 1'b1;
    run_phase(32'd16, 32'd3, 60);

    repeat (8) @(negedge clk);
    if (edge_q.size() != 0) begin
      $error("%0d expected results never arrived", edge_q.size());
      fail_count++;
    end
    $display("fed %0d pixel/flush items over widths 2..128 and row counts 0..65535",
             fed_count);
    $display("checked %0d edge results, %0d of them frame ends", edge_count, frame_count);
    if (fail_count == 0) begin
      $display("tb_sobel_edge_magnitude_stream: clean");
    end else begin
      $display("tb_sobel_edge_magnitude_stream: errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d items and %0d results outstanding", in_flight, edge_q.size());
    $display("tb_sobel_edge_magnitude_stream: errors");
    $finish;
  end

endmodule
